// File: src/gti_pkg.sv
`default_nettype none

package gti_pkg;

	localparam int unsigned CFG_W   = 9;
	localparam int unsigned ADDR_W  = 2;
	localparam int unsigned FIELD_W = 17;
	localparam int unsigned BASE_W  = 16;

	localparam logic [ADDR_W-1:0] REG_ROWS   = 2'd0;
	localparam logic [ADDR_W-1:0] REG_COLS   = 2'd1;
	localparam logic [ADDR_W-1:0] REG_U_WRAP = 2'd2;
	localparam logic [ADDR_W-1:0] REG_V_WRAP = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] slot;
		logic [FIELD_W-1:0] vert_a;
		logic [FIELD_W-1:0] vert_b;
		logic [FIELD_W-1:0] vert_c;
		logic               last;
	} tri_t;

endpackage

`default_nettype wire

// File: src/gti_walk.sv
`default_nettype none

module gti_walk #(
	parameter int unsigned SIDE_W = 9
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 clear,
	input  wire                 step,
	input  wire                 restart,
	input  wire  [SIDE_W-1:0]   nu,
	input  wire  [SIDE_W-1:0]   nv,
	input  wire  [SIDE_W-1:0]   nrows,
	input  wire  [SIDE_W-1:0]   ncols,
	output gti_pkg::tri_t       tri_out
);

	logic [SIDE_W-1:0]          row_q;
	logic [SIDE_W-1:0]          col_q;
	logic                       second_q;
	logic [gti_pkg::BASE_W-1:0] base_q;
	logic [gti_pkg::FIELD_W-1:0] slot_q;

	// state as seen by this item, after an optional restart
	logic [SIDE_W-1:0]          row_c;
	logic [SIDE_W-1:0]          col_c;
	logic                       second_c;
	logic [gti_pkg::BASE_W-1:0] base_c;
	logic [gti_pkg::FIELD_W-1:0] slot_c;

	logic [gti_pkg::FIELD_W-1:0] here;
	logic [gti_pkg::FIELD_W-1:0] next;
	logic [SIDE_W-1:0]          jn;
	logic                       col_end;
	logic                       row_end;

	always_comb begin
		if (restart) begin
			row_c    = SIDE_W'(1);
			col_c    = SIDE_W'(1);
			second_c = 1'b0;
			base_c   = '0;
			slot_c   = '0;
		end else begin
			row_c    = row_q;
			col_c    = col_q;
			second_c = second_q;
			base_c   = base_q;
			slot_c   = slot_q;
		end
	end

	always_comb begin
		here = gti_pkg::FIELD_W'(base_c);
		next = (row_c == nu) ? '0 : here + gti_pkg::FIELD_W'(nv);
		jn   = (col_c == nv) ? SIDE_W'(1) : col_c + SIDE_W'(1);
		col_end = (col_c >= ncols);
		row_end = (row_c >= nrows);

		tri_out.slot = slot_c;
		if (!second_c) begin
			tri_out.vert_a = here + gti_pkg::FIELD_W'(col_c);
			tri_out.vert_b = here + gti_pkg::FIELD_W'(jn);
		end else begin
			tri_out.vert_a = here + gti_pkg::FIELD_W'(jn);
			tri_out.vert_b = next + gti_pkg::FIELD_W'(jn);
		end
		tri_out.vert_c = next + gti_pkg::FIELD_W'(col_c);
		tri_out.last   = (row_c == nrows) && (col_c == ncols) && second_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= SIDE_W'(1);
			col_q    <= SIDE_W'(1);
			second_q <= 1'b0;
			base_q   <= '0;
			slot_q   <= '0;
		end else if (clear) begin
			row_q    <= SIDE_W'(1);
			col_q    <= SIDE_W'(1);
			second_q <= 1'b0;
			base_q   <= '0;
			slot_q   <= '0;
		end else if (step) begin
			slot_q <= slot_c + 1'b1;
			if (col_end) begin
				col_q <= SIDE_W'(1);
				if (row_end) begin
					row_q    <= SIDE_W'(1);
					base_q   <= '0;
					second_q <= !second_c;
					if (second_c) begin
						slot_q <= '0;
					end
				end else begin
					row_q    <= row_c + SIDE_W'(1);
					second_q <= second_c;
					base_q   <= base_c + gti_pkg::BASE_W'(nv);
				end
			end else begin
				col_q    <= col_c + SIDE_W'(1);
				row_q    <= row_c;
				second_q <= second_c;
				base_q   <= base_c;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/grid_triangle_index_generator.sv
`default_nettype none

// Walks the triangle list of a rows_count by cols_count vertex grid, one
// triangle per accepted item: all first-kind triangles cell by cell, then all
// second-kind ones, then the list repeats. Vertex numbers are one-based and
// row-major; u_wraps / v_wraps close the grid on itself. Sustained rate is one
// item per cycle while out_ready holds; an input stage feeds a result
// register; the walk counters and the accumulated row base are the only
// loop, and they advance once per item. A restart item emits the first
// triangle. Any configuration write returns the walk to the first triangle.

module grid_triangle_index_generator #(
	parameter int unsigned MAX_SIDE = 256
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [gti_pkg::ADDR_W-1:0]     cfg_addr,
	input  wire  [gti_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            restart,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [gti_pkg::FIELD_W-1:0]    triangle_slot,
	output logic [gti_pkg::FIELD_W-1:0]    vertex_a,
	output logic [gti_pkg::FIELD_W-1:0]    vertex_b,
	output logic [gti_pkg::FIELD_W-1:0]    vertex_c,
	output logic                           final_triangle
);

	localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);

	logic [gti_pkg::CFG_W-1:0] rows_q;
	logic [gti_pkg::CFG_W-1:0] cols_q;
	logic                      u_wrap_q;
	logic                      v_wrap_q;

	logic [SIDE_W-1:0] nu;
	logic [SIDE_W-1:0] nv;
	logic [SIDE_W-1:0] nrows;
	logic [SIDE_W-1:0] ncols;

	logic          valid_s1;
	logic          restart_s1;
	logic          advance;
	logic          out_valid_q;
	gti_pkg::tri_t tri_c;
	gti_pkg::tri_t out_tri_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= gti_pkg::CFG_W'(2);
			cols_q   <= gti_pkg::CFG_W'(2);
			u_wrap_q <= 1'b0;
			v_wrap_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				gti_pkg::REG_ROWS:   rows_q   <= cfg_wdata;
				gti_pkg::REG_COLS:   cols_q   <= cfg_wdata;
				gti_pkg::REG_U_WRAP: u_wrap_q <= cfg_wdata[0];
				gti_pkg::REG_V_WRAP: v_wrap_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamp sizes to 2..MAX_SIDE
	always_comb begin
		if (rows_q < gti_pkg::CFG_W'(2)) begin
			nu = SIDE_W'(2);
		end else if (32'(rows_q) > MAX_SIDE) begin
			nu = SIDE_W'(MAX_SIDE);
		end else begin
			nu = SIDE_W'(rows_q);
		end
		if (cols_q < gti_pkg::CFG_W'(2)) begin
			nv = SIDE_W'(2);
		end else if (32'(cols_q) > MAX_SIDE) begin
			nv = SIDE_W'(MAX_SIDE);
		end else begin
			nv = SIDE_W'(cols_q);
		end
		nrows = nu - SIDE_W'(1) + SIDE_W'(u_wrap_q);
		ncols = nv - SIDE_W'(1) + SIDE_W'(v_wrap_q);
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			restart_s1 <= restart;
		end
	end

	gti_walk #(
		.SIDE_W (SIDE_W)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_we),
		.step    (advance),
		.restart (restart_s1),
		.nu      (nu),
		.nv      (nv),
		.nrows   (nrows),
		.ncols   (ncols),
		.tri_out (tri_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_tri_q <= tri_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign triangle_slot  = out_tri_q.slot;
	assign vertex_a       = out_tri_q.vert_a;
	assign vertex_b       = out_tri_q.vert_b;
	assign vertex_c       = out_tri_q.vert_c;
	assign final_triangle = out_tri_q.last;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input not ready with empty stage");

	a_stage_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item did not reach result register");

	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && restart_s1) |=> (out_valid && triangle_slot == '0))
		else $error("restart item is not the first triangle");

	a_vertex_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (vertex_a != '0 && vertex_b != '0 && vertex_c != '0))
		else $error("vertex number zero");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;

	// tracks the walk over the grid and keeps the triangles still owed by the block
	class triangle_scoreboard;
		logic [gti_pkg::CFG_W-1:0]   rows_reg;
		logic [gti_pkg::CFG_W-1:0]   cols_reg;
		bit                          u_wrap;
		bit                          v_wrap;
		int unsigned                 row_i;
		int unsigned                 col_j;
		bit                          second_kind;
		logic [gti_pkg::BASE_W-1:0]  base;
		logic [gti_pkg::FIELD_W-1:0] slot;
		gti_pkg::tri_t               triangles_due[$];
		int                          errors;

		function new();
			rows_reg = 9'd2;
			cols_reg = 9'd2;
			u_wrap = 1'b0;
			v_wrap = 1'b0;
			errors = 0;
			restart_walk();
		endfunction

		function void restart_walk();
			row_i = 1;
			col_j = 1;
			second_kind = 1'b0;
			base = '0;
			slot = '0;
		endfunction

		function int unsigned side(logic [gti_pkg::CFG_W-1:0] n);
			if (n < 2)
				return 2;
			if (n > 256)
				return 256;
			return 32'(n);
		endfunction

		function void write_reg(logic [gti_pkg::ADDR_W-1:0] addr,
				logic [gti_pkg::CFG_W-1:0] data);
			case (addr)
				gti_pkg::REG_ROWS:   rows_reg = data;
				gti_pkg::REG_COLS:   cols_reg = data;
				gti_pkg::REG_U_WRAP: u_wrap = data[0];
				gti_pkg::REG_V_WRAP: v_wrap = data[0];
			endcase
			restart_walk();
		endfunction

		function int unsigned cell_rows();
			return side(rows_reg) - 1 + u_wrap;
		endfunction

		function int unsigned cell_cols();
			return side(cols_reg) - 1 + v_wrap;
		endfunction

		function int unsigned mesh_length();
			return 2 * cell_rows() * cell_cols();
		endfunction

		function int pending();
			return triangles_due.size();
		endfunction

		// triangle the block owes for one accepted item, then step the walk
		function void next_triangle(bit rs);
			int unsigned nu, nv, nr, nc, here, below, jn, a, b, c;
			gti_pkg::tri_t t;
			nu = side(rows_reg);
			nv = side(cols_reg);
			nr = cell_rows();
			nc = cell_cols();
			if (rs)
				restart_walk();
			here = 32'(base);
			below = (row_i == nu) ? 0 : here + nv;
			jn = (col_j == nv) ? 1 : col_j + 1;
			if (!second_kind) begin
				a = here + col_j;
				b = here + jn;
				c = below + col_j;
			end else begin
				a = here + jn;
				b = below + jn;
				c = below + col_j;
			end
			t.slot = slot;
			t.vert_a = a[gti_pkg::FIELD_W-1:0];
			t.vert_b = b[gti_pkg::FIELD_W-1:0];
			t.vert_c = c[gti_pkg::FIELD_W-1:0];
			t.last = (row_i == nr) && (col_j == nc) && second_kind;
			triangles_due.push_back(t);

			slot = slot + 1'b1;
			if (col_j >= nc) begin
				col_j = 1;
				if (row_i >= nr) begin
					row_i = 1;
					base = '0;
					if (second_kind) begin
						second_kind = 1'b0;
						slot = '0;
					end else begin
						second_kind = 1'b1;
					end
				end else begin
					row_i = row_i + 1;
					base = base + nv[gti_pkg::BASE_W-1:0];
				end
			end else begin
				col_j = col_j + 1;
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(gti_pkg::tri_t got);
			gti_pkg::tri_t want;
			if (triangles_due.size() == 0) begin
				report_mismatch($sformatf("triangle slot %0d with no item pending",
					got.slot));
				return;
			end
			want = triangles_due.pop_front();
			if (got.slot !== want.slot)
				report_mismatch($sformatf("triangle_slot %0d, want %0d", got.slot, want.slot));
			if (got.vert_a !== want.vert_a)
				report_mismatch($sformatf("slot %0d vertex_a %0d, want %0d",
					want.slot, got.vert_a, want.vert_a));
			if (got.vert_b !== want.vert_b)
				report_mismatch($sformatf("slot %0d vertex_b %0d, want %0d",
					want.slot, got.vert_b, want.vert_b));
			if (got.vert_c !== want.vert_c)
				report_mismatch($sformatf("slot %0d vertex_c %0d, want %0d",
					want.slot, got.vert_c, want.vert_c));
			if (got.last !== want.last)
				report_mismatch($sformatf("slot %0d final_triangle %0b, want %0b",
					want.slot, got.last, want.last));
		endtask

		task finish_check();
			if (triangles_due.size() != 0)
				report_mismatch($sformatf("%0d triangles never arrived",
					triangles_due.size()));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [gti_pkg::ADDR_W-1:0]  cfg_addr;
	logic [gti_pkg::CFG_W-1:0]   cfg_wdata;
	logic                        in_valid;
	logic                        in_ready;
	logic                        restart;
	logic                        out_valid;
	logic                        out_ready;
	logic [gti_pkg::FIELD_W-1:0] triangle_slot;
	logic [gti_pkg::FIELD_W-1:0] vertex_a;
	logic [gti_pkg::FIELD_W-1:0] vertex_b;
	logic [gti_pkg::FIELD_W-1:0] vertex_c;
	logic                        final_triangle;

	triangle_scoreboard sb = new();
	bit tx_calm;
	bit stall_req;

	grid_triangle_index_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.triangle_slot(triangle_slot),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.vertex_c(vertex_c),
		.final_triangle(final_triangle)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin : result_monitor
		gti_pkg::tri_t got;
		if (arst_n && out_valid && out_ready) begin
			got.slot = triangle_slot;
			got.vert_a = vertex_a;
			got.vert_b = vertex_b;
			got.vert_c = vertex_c;
			got.last = final_triangle;
			sb.check_result(got);
		end
	end

	// result side: random stalls, calm stretches, and one long hold-off on request
	initial begin : result_taker
		int unsigned gap;
		int unsigned left;
		bit calm;
		out_ready = 0;
		calm = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			if (left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				left = $urandom_range(20, 80);
			end
			left--;
			if (stall_req) begin
				stall_req = 0;
				repeat (300) @(negedge clk) out_ready = 0;
			end
			gap = calm ? 0 : $urandom_range(0, 7);
			repeat (gap) @(negedge clk) out_ready = 0;
			@(negedge clk) out_ready = 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// called at a falling edge, returns at a falling edge
	task send_item(bit rs);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		restart = rs;
		do @(posedge clk); while (!in_ready);
		sb.next_triangle(rs);
		@(negedge clk);
	endtask

	task wait_drained();
		in_valid = 0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(logic [gti_pkg::ADDR_W-1:0] addr, logic [gti_pkg::CFG_W-1:0] data);
		cfg_we = 1;
		cfg_addr = addr;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 0;
		sb.write_reg(addr, data);
	endtask

	// junk in the upper bits of the wrap registers must be ignored
	task set_grid(logic [gti_pkg::CFG_W-1:0] rows, logic [gti_pkg::CFG_W-1:0] cols,
			bit uw, bit vw, bit junk);
		logic [7:0] ju, jv;
		ju = junk ? 8'($urandom) : 8'd0;
		jv = junk ? 8'($urandom) : 8'd0;
		wait_drained();
		write_reg(gti_pkg::REG_ROWS, rows);
		write_reg(gti_pkg::REG_COLS, cols);
		write_reg(gti_pkg::REG_U_WRAP, {ju, uw});
		write_reg(gti_pkg::REG_V_WRAP, {jv, vw});
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		bit pressed;
		logic [gti_pkg::CFG_W-1:0] rows, cols;

		cfg_we = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 0;
		restart = 0;
		stall_req = 0;
		tx_calm = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;
		@(negedge clk);

		// reset sizes: one cell, two triangles, then wrap around and restart
		send_item(0);
		send_item(0);
		send_item(0);
		send_item(1);
		send_item(0);

		// periodic both ways, restart mid-row
		set_grid(9'd3, 9'd4, 1, 1, 0);
		repeat (6) send_item(0);
		send_item(1);

		// sizes below range clamp up to two
		set_grid(9'd0, 9'd1, 0, 0, 1);
		send_item(0);
		send_item(0);

		// sizes above range clamp to the largest grid
		set_grid(9'd511, 9'd300, 1, 1, 1);
		repeat (3) send_item(0);
		send_item(1);

		// a single register write mid-walk sends the walk back to the start
		wait_drained();
		write_reg(gti_pkg::REG_V_WRAP, 9'd0);
		send_item(0);
		send_item(0);

		// full walks along a long row and a tall column
		tx_calm = 1;
		set_grid(9'd2, 9'd40, 0, 1, 0);
		repeat (sb.mesh_length() + 1) send_item(0);
		set_grid(9'd40, 9'd2, 1, 0, 0);
		repeat (sb.mesh_length() + 1) send_item(0);

		sent = 0;
		pressed = 0;
		while (sent < 300) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				rows = 9'($urandom_range(2, 6));
				cols = 9'($urandom_range(2, 6));
			end else if (pick == 8) begin
				rows = 9'($urandom_range(0, 1) ? $urandom_range(0, 1)
					: $urandom_range(257, 511));
				cols = 9'($urandom_range(0, 1) ? $urandom_range(0, 1)
					: $urandom_range(2, 5));
			end else begin
				rows = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(2, 3));
				cols = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(2, 3));
			end
			set_grid(rows, cols, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			tx_calm = ($urandom_range(0, 3) == 0);
			if (!pressed && sent > 100) begin
				// hold the result side off while items keep coming
				pressed = 1;
				tx_calm = 1;
				stall_req = 1;
				len = 40;
			end else if (sb.mesh_length() <= 72 && $urandom_range(0, 1)) begin
				len = sb.mesh_length() + $urandom_range(0, sb.mesh_length());
			end else begin
				len = $urandom_range(1, 40);
			end
			repeat (len) begin
				send_item($urandom_range(0, 15) == 0);
				sent++;
			end
		end

		in_valid = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		sb.finish_check();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
